@@ sv/swam_pkg.sv @@
// Shared constants, types and the result record of the sliding window average block.
package swam_pkg;

    localparam int DEPTH      = 256;
    localparam int SAMPLE_W   = 16;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int LEN_W      = 9;
    localparam int SUM_W      = SAMPLE_W + PTR_W;
    localparam int DIV_STEP_W = $clog2(SUM_W + 1);
    localparam int ADDR_W     = 2;
    localparam int DATA_W     = 32;

    localparam logic [LEN_W-1:0]  LEN_RESET          = LEN_W'(256);
    localparam logic [ADDR_W-1:0] ADDR_WINDOW_LENGTH = '0;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic signed [SAMPLE_W-1:0] window_minimum;
        logic signed [SAMPLE_W-1:0] window_maximum;
        logic        [CNT_W-1:0]    sample_count;
        logic                       ready_res;
        logic                       window_empty;
        logic signed [SAMPLE_W-1:0] popped_value;
        logic                       pop_failed;
    } t_result;

endpackage

@@ sv/swam_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module swam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/swam_div.sv @@
// Iterative restoring divider: signed window sum by unsigned count, one quotient bit a cycle.
module swam_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [swam_pkg::SUM_W-1:0]       i_dividend,
    input  logic        [swam_pkg::CNT_W-1:0]       i_divisor,
    output logic                                    o_busy,
    output logic signed [swam_pkg::SAMPLE_W-1:0]    o_quotient
);
    import swam_pkg::*;

    logic [DIV_STEP_W-1:0] r_step, n_step;
    logic                  r_neg, n_neg;
    logic [SUM_W-1:0]      r_quo, n_quo;
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic [CNT_W-1:0]      r_div, n_div;
    logic [CNT_W:0]        trial;
    logic [SUM_W-1:0]      quo_signed;

    assign trial = {r_rem, r_quo[SUM_W-1]};

    always_comb begin
        n_step = r_step;
        n_neg  = r_neg;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_step = DIV_STEP_W'(SUM_W);
            n_neg  = i_dividend[SUM_W-1];
            n_quo  = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_step != '0) begin
            n_step = r_step - DIV_STEP_W'(1);
            if (trial >= {1'b0, r_div}) begin
                n_rem = CNT_W'(trial - {1'b0, r_div});
                n_quo = {r_quo[SUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial[CNT_W-1:0];
                n_quo = {r_quo[SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
        r_neg <= n_neg;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_quotient = quo_signed[SAMPLE_W-1:0];
    assign o_busy     = (r_step != '0);

endmodule

@@ sv/swam_ctrl.sv @@
// Window sequencer: ring pointers, running sum, sample memory update and min/max scan.
module swam_ctrl (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_clear,
    input  logic        [swam_pkg::CNT_W-1:0]  i_len,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic signed [swam_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_res_valid,
    input  logic                               i_res_take,
    output swam_pkg::t_result                  o_res
);
    import swam_pkg::*;

    t_state r_state, n_state;

    logic        [PTR_W-1:0]    r_wp, n_wp;
    logic        [PTR_W-1:0]    r_rp, n_rp;
    logic        [CNT_W-1:0]    r_cnt, n_cnt;
    logic signed [SUM_W-1:0]    r_sum, n_sum;
    logic                       r_cmd;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_popped, n_popped;
    logic                       r_failed, n_failed;
    logic        [PTR_W-1:0]    r_scan_ptr, n_scan_ptr;
    logic        [CNT_W-1:0]    r_issue_left, n_issue_left;
    logic                       r_data_vld, n_data_vld;
    logic signed [SAMPLE_W-1:0] r_lo, n_lo;
    logic signed [SAMPLE_W-1:0] r_hi, n_hi;

    logic                       ram_we;
    logic        [PTR_W-1:0]    ram_waddr;
    logic        [SAMPLE_W-1:0] ram_wdata;
    logic        [PTR_W-1:0]    ram_raddr;
    logic        [SAMPLE_W-1:0] ram_rdata;
    logic signed [SAMPLE_W-1:0] rd_s;

    logic                       div_start;
    logic                       div_busy;
    logic signed [SAMPLE_W-1:0] div_q;

    logic                       scan_done;
    logic                       empty;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] len);
        if (CNT_W'(p) + CNT_W'(1) == len) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    swam_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    swam_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_cnt),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign rd_s      = ram_rdata;
    assign scan_done = (r_issue_left == '0) && !r_data_vld;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_done && !div_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_wp         = r_wp;
        n_rp         = r_rp;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_popped     = r_popped;
        n_failed     = r_failed;
        n_scan_ptr   = r_scan_ptr;
        n_issue_left = r_issue_left;
        n_data_vld   = 1'b0;
        n_lo         = r_lo;
        n_hi         = r_hi;
        ram_we       = 1'b0;
        ram_waddr    = r_wp;
        ram_wdata    = r_sample;
        ram_raddr    = r_rp;
        div_start    = 1'b0;
        unique case (r_state)
            S_UPDATE: begin
                n_popped = '0;
                n_failed = 1'b0;
                if (r_cmd == CMD_PUSH) begin
                    ram_we = 1'b1;
                    n_wp   = ptr_inc(r_wp, i_len);
                    if (r_cnt == i_len) begin
                        n_rp  = ptr_inc(r_rp, i_len);
                        n_sum = r_sum + SUM_W'(r_sample) - SUM_W'(rd_s);
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                        n_sum = r_sum + SUM_W'(r_sample);
                    end
                end else if (r_cnt == '0) begin
                    n_failed = 1'b1;
                end else begin
                    n_popped = rd_s;
                    n_rp     = ptr_inc(r_rp, i_len);
                    n_sum    = r_sum - SUM_W'(rd_s);
                    n_cnt    = r_cnt - CNT_W'(1);
                end
                n_scan_ptr   = n_rp;
                n_issue_left = n_cnt;
                n_lo         = {1'b0, {(SAMPLE_W-1){1'b1}}};
                n_hi         = {1'b1, {(SAMPLE_W-1){1'b0}}};
                div_start    = 1'b1;
            end
            S_SCAN: begin
                ram_raddr = r_scan_ptr;
                if (r_issue_left != '0) begin
                    n_scan_ptr   = ptr_inc(r_scan_ptr, i_len);
                    n_issue_left = r_issue_left - CNT_W'(1);
                    n_data_vld   = 1'b1;
                end
                if (r_data_vld) begin
                    if (rd_s < r_lo) begin
                        n_lo = rd_s;
                    end
                    if (rd_s > r_hi) begin
                        n_hi = rd_s;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wp         <= '0;
            r_rp         <= '0;
            r_cnt        <= '0;
            r_sum        <= '0;
            r_issue_left <= '0;
            r_data_vld   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_issue_left <= n_issue_left;
            r_data_vld   <= n_data_vld;
            if (i_clear) begin
                r_wp  <= '0;
                r_rp  <= '0;
                r_cnt <= '0;
                r_sum <= '0;
            end else begin
                r_wp  <= n_wp;
                r_rp  <= n_rp;
                r_cnt <= n_cnt;
                r_sum <= n_sum;
            end
        end
        if (r_state == S_IDLE) begin
            r_cmd    <= i_command;
            r_sample <= i_sample;
        end
        r_popped   <= n_popped;
        r_failed   <= n_failed;
        r_scan_ptr <= n_scan_ptr;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
    end

    assign empty = (r_cnt == '0);

    always_comb begin
        o_in_stall           = (r_state != S_IDLE);
        o_res_valid          = (r_state == S_DONE);
        o_res.mean_value     = empty ? '0 : div_q;
        o_res.window_minimum = empty ? '0 : r_lo;
        o_res.window_maximum = empty ? '0 : r_hi;
        o_res.sample_count   = r_cnt;
        o_res.ready_res      = (r_cnt >= (i_len >> 1));
        o_res.window_empty   = empty;
        o_res.popped_value   = r_popped;
        o_res.pop_failed     = r_failed;
    end

endmodule

@@ sv/sliding_window_average_min_max_top.sv @@
// Top level of the sliding window average, minimum and maximum block.
//
// Input channel: i_in_valid / o_in_stall with i_command (push or pop) and
// i_sample. Output channel: o_out_valid / i_out_stall carrying one result
// item per input item: mean, minimum, maximum, count and status flags.
// An item is taken at a clock edge with valid high and stall low.
// Samples live in a single 256-entry RAM with registered read data.
// The min/max scan reads one stored sample a cycle through the RAM read
// port, while the iterative divider for the mean runs alongside it; an
// item ends when both are done, so the longest item is one with a full
// window of 256 samples. One item is in flight at a time; the next is
// accepted while a finished result still waits in the output register.
// The APB port holds window_length at address 0; writing it clears the
// window. Reset (synchronous, active low) empties the window and sets the
// length to 256. While the receiver stalls, the result holds and the
// block stops after finishing the following item.
module sliding_window_average_min_max_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic        [swam_pkg::ADDR_W-1:0]     paddr,
    input  logic        [swam_pkg::DATA_W-1:0]     pwdata,
    output logic        [swam_pkg::DATA_W-1:0]     prdata,
    output logic                                   pready,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_command,
    input  logic signed [swam_pkg::SAMPLE_W-1:0]   i_sample,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [swam_pkg::SAMPLE_W-1:0]   o_mean_value,
    output logic signed [swam_pkg::SAMPLE_W-1:0]   o_window_minimum,
    output logic signed [swam_pkg::SAMPLE_W-1:0]   o_window_maximum,
    output logic        [swam_pkg::CNT_W-1:0]      o_sample_count,
    output logic                                   o_ready_res,
    output logic                                   o_window_empty,
    output logic signed [swam_pkg::SAMPLE_W-1:0]   o_popped_value,
    output logic                                   o_pop_failed
);
    import swam_pkg::*;

    localparam int EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [LEN_W-1:0] r_len;
    logic [EXT_W-1:0] len_ext;
    logic [CNT_W-1:0] eff_len;
    logic             cfg_we;
    logic             res_valid;
    logic             res_take;
    logic             slot_free;
    t_result          res;
    logic             r_out_valid;
    t_result          r_res;

    assign cfg_we = psel && penable && pwrite && (paddr == ADDR_WINDOW_LENGTH);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? DATA_W'(r_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (cfg_we) begin
            r_len <= pwdata[LEN_W-1:0];
        end
    end

    // clamp length into 1..DEPTH
    assign len_ext = EXT_W'(r_len);
    always_comb begin
        priority if (len_ext == '0) begin
            eff_len = CNT_W'(1);
        end else if (len_ext > EXT_W'(DEPTH)) begin
            eff_len = CNT_W'(DEPTH);
        end else begin
            eff_len = CNT_W'(len_ext);
        end
    end

    swam_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (cfg_we),
        .i_len       (eff_len),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_sample    (i_sample),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    assign slot_free = !r_out_valid || !i_out_stall;
    assign res_take  = res_valid && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res_take) begin
            r_res <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mean_value     = r_res.mean_value;
    assign o_window_minimum = r_res.window_minimum;
    assign o_window_maximum = r_res.window_maximum;
    assign o_sample_count   = r_res.sample_count;
    assign o_ready_res      = r_res.ready_res;
    assign o_window_empty   = r_res.window_empty;
    assign o_popped_value   = r_res.popped_value;
    assign o_pop_failed     = r_res.pop_failed;

endmodule

@@ sv/swam_checker.sv @@
// Port-level assertions for the sliding window average block, bound to the top level.
module swam_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic signed [swam_pkg::SAMPLE_W-1:0]   o_mean_value,
    input logic signed [swam_pkg::SAMPLE_W-1:0]   o_window_minimum,
    input logic signed [swam_pkg::SAMPLE_W-1:0]   o_window_maximum,
    input logic        [swam_pkg::CNT_W-1:0]      o_sample_count,
    input logic                                   o_window_empty,
    input logic signed [swam_pkg::SAMPLE_W-1:0]   o_popped_value,
    input logic                                   o_pop_failed
);
    import swam_pkg::*;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_window_empty |->
            (o_mean_value == '0) && (o_window_minimum == '0) && (o_window_maximum == '0))
        else $error("empty window result carries nonzero statistics");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_sample_count == '0) == o_window_empty))
        else $error("empty flag disagrees with count");

    a_fail_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pop_failed |-> o_window_empty && (o_popped_value == '0))
        else $error("failed pop with nonempty window or nonzero value");

    a_mean_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_window_empty |->
            (o_window_minimum <= o_mean_value) && (o_mean_value <= o_window_maximum))
        else $error("mean outside window minimum and maximum");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while one is in flight");

endmodule

bind sliding_window_average_min_max_top swam_checker u_swam_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .o_mean_value     (o_mean_value),
    .o_window_minimum (o_window_minimum),
    .o_window_maximum (o_window_maximum),
    .o_sample_count   (o_sample_count),
    .o_window_empty   (o_window_empty),
    .o_popped_value   (o_popped_value),
    .o_pop_failed     (o_pop_failed)
);

@@ tb/sliding_window_average_min_max_top_tb.sv @@
// Testbench for the sliding window average, minimum and maximum block: random and directed items checked against a built-in window predictor.
`timescale 1ns / 100ps

module sliding_window_average_min_max_top_tb;
    import swam_pkg::*;

    localparam int RUN_LIMIT_NS = 20_000_000;
    localparam int DRAIN_CYCLES = 300;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic        [ADDR_W-1:0]     paddr = '0;
    logic        [DATA_W-1:0]     pwdata = '0;
    logic        [DATA_W-1:0]     prdata;
    logic                         pready;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic                         i_command = CMD_PUSH;
    logic signed [SAMPLE_W-1:0]   i_sample = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]   o_mean_value;
    logic signed [SAMPLE_W-1:0]   o_window_minimum;
    logic signed [SAMPLE_W-1:0]   o_window_maximum;
    logic        [CNT_W-1:0]      o_sample_count;
    logic                         o_ready_res;
    logic                         o_window_empty;
    logic signed [SAMPLE_W-1:0]   o_popped_value;
    logic                         o_pop_failed;

    sliding_window_average_min_max_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_sample         (i_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mean_value     (o_mean_value),
        .o_window_minimum (o_window_minimum),
        .o_window_maximum (o_window_maximum),
        .o_sample_count   (o_sample_count),
        .o_ready_res      (o_ready_res),
        .o_window_empty   (o_window_empty),
        .o_popped_value   (o_popped_value),
        .o_pop_failed     (o_pop_failed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    logic signed [SAMPLE_W-1:0] ring [DEPTH];
    int          wr_ptr;
    int          rd_ptr;
    bit          ring_full;
    longint      window_sum;
    int          length_reg;
    t_result     pending_stats [$];
    int          fail_count;
    bit          idle_on;
    int          stall_left;
    int          run_left;

    function automatic int active_length();
        if (length_reg == 0) return 1;
        if (length_reg > DEPTH) return DEPTH;
        return length_reg;
    endfunction

    function automatic int held_count(int len);
        if (ring_full) return len;
        return (wr_ptr + len - rd_ptr) % len;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] take_oldest(int len);
        logic signed [SAMPLE_W-1:0] oldest;
        oldest = ring[rd_ptr];
        rd_ptr = (rd_ptr + 1) % len;
        window_sum -= oldest;
        ring_full = 1'b0;
        return oldest;
    endfunction

    function automatic void set_window_length(int value);
        length_reg = value & 'h1FF;
        wr_ptr = 0;
        rd_ptr = 0;
        ring_full = 1'b0;
        window_sum = 0;
    endfunction

    function automatic t_result next_window_stats(logic cmd, logic signed [SAMPLE_W-1:0] s);
        t_result                    r;
        int                         len;
        int                         cnt;
        int                         pos;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        r = '0;
        len = active_length();
        wr_ptr = wr_ptr % len;
        rd_ptr = rd_ptr % len;
        if (cmd == CMD_PUSH) begin
            if (ring_full) void'(take_oldest(len));
            ring[wr_ptr] = s;
            wr_ptr = (wr_ptr + 1) % len;
            if (wr_ptr == rd_ptr) ring_full = 1'b1;
            window_sum += s;
        end else if (held_count(len) == 0) begin
            r.pop_failed = 1'b1;
        end else begin
            r.popped_value = take_oldest(len);
        end
        cnt = held_count(len);
        if (cnt != 0) begin
            r.mean_value = SAMPLE_W'(window_sum / cnt);
            pos = rd_ptr;
            lo = ring[pos];
            hi = ring[pos];
            for (int i = 0; i < cnt; i++) begin
                if (ring[pos] < lo) lo = ring[pos];
                if (ring[pos] > hi) hi = ring[pos];
                pos = (pos + 1) % len;
            end
            r.window_minimum = lo;
            r.window_maximum = hi;
        end
        r.sample_count = CNT_W'(cnt);
        r.ready_res    = (cnt >= len / 2);
        r.window_empty = (cnt == 0);
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'($urandom_range(0, 15)) - 16'sd8;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, $signed(exp_v),
                   $signed(act_v));
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_stats.size() == 0) begin
                $error("result item arrived with no item outstanding");
                fail_count++;
            end else begin
                want = pending_stats.pop_front();
                check_field("mean_value", want.mean_value, o_mean_value);
                check_field("window_minimum", want.window_minimum, o_window_minimum);
                check_field("window_maximum", want.window_maximum, o_window_maximum);
                check_field("sample_count", 16'(want.sample_count), 16'(o_sample_count));
                check_field("ready_res", 16'(want.ready_res), 16'(o_ready_res));
                check_field("window_empty", 16'(want.window_empty), 16'(o_window_empty));
                check_field("popped_value", want.popped_value, o_popped_value);
                check_field("pop_failed", 16'(want.pop_failed), 16'(o_pop_failed));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!idle_on) begin
            stall_left = 0;
            run_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (run_left > 0) begin
            run_left--;
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_out_stall <= 1'b1;
        end else begin
            run_left = $urandom_range(0, 15);
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_item(logic cmd, logic signed [SAMPLE_W-1:0] s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        pending_stats.push_back(next_window_stats(cmd, s));
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_length(int value);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WINDOW_LENGTH;
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        set_window_length(value);
    endtask

    task automatic run_random(int count, int push_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1, 100) <= push_pct) send_item(CMD_PUSH, pick_sample());
            else send_item(CMD_POP, pick_sample());
        end
    endtask

    task automatic test_directed();
        send_item(CMD_POP, 16'sh1234);
        send_item(CMD_PUSH, 16'sh7FFF);
        send_item(CMD_PUSH, 16'sh8000);
        send_item(CMD_PUSH, 16'sh0000);
        send_item(CMD_PUSH, -16'sd1);
        send_item(CMD_PUSH, 16'sd1);
        send_item(CMD_POP, 16'sh0000);
        send_item(CMD_POP, 16'shFFFF);
        write_length(1);
        send_item(CMD_POP, 16'sh0000);
        send_item(CMD_PUSH, 16'sd100);
        send_item(CMD_PUSH, -16'sd200);
        send_item(CMD_POP, 16'sh0000);
        write_length(0);
        send_item(CMD_PUSH, 16'sh7FFF);
        send_item(CMD_PUSH, 16'sh8000);
        write_length(3);
        send_item(CMD_PUSH, 16'sh7FFF);
        send_item(CMD_PUSH, 16'sh7FFF);
        send_item(CMD_PUSH, 16'sh7FFF);
        send_item(CMD_PUSH, -16'sd5);
        send_item(CMD_POP, 16'sh0000);
        write_length(511);
        send_item(CMD_PUSH, 16'sh8000);
        send_item(CMD_POP, 16'sh0000);
        send_item(CMD_POP, 16'sh0000);
    endtask

    task automatic test_random_lengths();
        int fixed_len [4] = '{1, 2, 0, 3};
        for (int i = 0; i < 12; i++) begin
            write_length((i < 4) ? fixed_len[i] : $urandom_range(4, 48));
            run_random(100, (i % 3 == 0) ? 40 : 75);
        end
    endtask

    task automatic test_full_window();
        write_length(300);
        run_random(400, 92);
        write_length(256);
        run_random(60, 30);
    endtask

    task automatic test_quiet_tail();
        write_length($urandom_range(5, 31));
        idle_on = 1'b0;
        run_random(200, 65);
    endtask

    initial begin
        fail_count = 0;
        idle_on = 1'b0;
        set_window_length(LEN_RESET);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;
        test_directed();
        test_random_lengths();
        test_full_window();
        test_quiet_tail();
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sliding_window_average_min_max_top.f @@
sv/swam_pkg.sv
sv/swam_ram.sv
sv/swam_div.sv
sv/swam_ctrl.sv
sv/sliding_window_average_min_max_top.sv
sv/swam_checker.sv
tb/sliding_window_average_min_max_top_tb.sv
